// ===== rtl/kmds_pkg.sv =====
// Shared types, constants and functions for the key matrix debounce scanner.
package kmds_pkg;

    localparam int NUM_ROWS      = 6;
    localparam int NUM_COLS      = 10;
    localparam int POWER_KEY_BIT = 60;
    localparam int ROW_STRIDE    = 10;
    localparam int MASK_BITS     = 64;

    typedef struct packed {
        logic [2:0] row_index;
        logic [9:0] column_levels;
        logic       power_level;
    } t_kmds_in;

    typedef struct packed {
        logic [63:0] scan_mask;
        logic        key_valid;
        logic [5:0]  key_number;
    } t_kmds_out;

    // Result of one processed row reading
    typedef struct packed {
        logic      valid;
        t_kmds_out data;
    } t_kmds_res;

    // Status of the result buffer seen by the top level
    typedef struct packed {
        logic room;
    } t_kmds_buf_st;

    // Lowest set bit of a 64-bit word: pick the lowest nonzero byte, then the bit in it.
    function automatic logic [5:0] lowest_bit(input logic [63:0] v);
        logic [2:0] grp;
        logic [2:0] bit_pos;
        logic [7:0] byte_sel;
        logic       found_g;
        logic       found_b;
        grp      = 3'd0;
        bit_pos  = 3'd0;
        found_g  = 1'b0;
        found_b  = 1'b0;
        for (int g = 0; g < 8; g++) begin
            if (!found_g && (v[g*8 +: 8] != 8'd0)) begin
                grp     = 3'(g);
                found_g = 1'b1;
            end
        end
        byte_sel = v[{grp, 3'b000} +: 8];
        for (int b = 0; b < 8; b++) begin
            if (!found_b && byte_sel[b]) begin
                bit_pos = 3'(b);
                found_b = 1'b1;
            end
        end
        return {grp, bit_pos};
    endfunction

endpackage

// ===== rtl/kmds_core.sv =====
// Scan accumulation, pairwise debounce and new-press detection.
module kmds_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  kmds_pkg::t_kmds_in i_data,
    output kmds_pkg::t_kmds_res o_res
);

    logic [63:0] r_acc,   n_acc;
    logic [63:0] r_first, n_first;
    logic        r_phase, n_phase;
    logic [63:0] r_held,  n_held;

    logic [63:0] row_mask;
    logic [63:0] scan;
    logic [63:0] stable;
    logic [63:0] fresh;
    logic [6:0]  pos;
    logic        row_ok;
    logic        last_row;

    always_comb begin
        row_mask = 64'd0;
        for (int c = 0; c < kmds_pkg::NUM_COLS && c < kmds_pkg::ROW_STRIDE; c++) begin
            pos = 7'(int'(i_data.row_index) * kmds_pkg::ROW_STRIDE + c);
            if (pos < 7'(kmds_pkg::MASK_BITS) && !i_data.column_levels[c]) begin
                row_mask[pos[5:0]] = 1'b1;
            end
        end
    end

    assign row_ok   = i_data.row_index < 3'(kmds_pkg::NUM_ROWS);
    assign last_row = i_data.row_index == 3'(kmds_pkg::NUM_ROWS - 1);

    always_comb begin
        scan = r_acc | row_mask;
        if (!i_data.power_level) begin
            scan[kmds_pkg::POWER_KEY_BIT % 64] = 1'b1;
        end
        stable = r_first & scan;
        fresh  = stable & ~r_held;

        n_acc   = r_acc;
        n_first = r_first;
        n_phase = r_phase;
        n_held  = r_held;

        o_res.valid           = 1'b0;
        o_res.data.scan_mask  = scan;
        o_res.data.key_valid  = 1'b0;
        o_res.data.key_number = 6'd0;

        if (i_fire && row_ok) begin
            if (!last_row) begin
                n_acc = r_acc | row_mask;
            end else begin
                // complete the scan and restart accumulation
                n_acc       = 64'd0;
                o_res.valid = 1'b1;
                if (!r_phase) begin
                    n_first = scan;
                    n_phase = 1'b1;
                end else begin
                    n_held  = (r_held & (r_first | scan)) | stable;
                    n_phase = 1'b0;
                    if (fresh != 64'd0) begin
                        o_res.data.key_valid  = 1'b1;
                        o_res.data.key_number = kmds_pkg::lowest_bit(fresh);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 64'd0;
            r_first <= 64'd0;
            r_phase <= 1'b0;
            r_held  <= 64'd0;
        end else begin
            r_acc   <= n_acc;
            r_first <= n_first;
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/kmds_out_buf.sv =====
// Two-entry result buffer that decouples the result side from the input side.
module kmds_out_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  kmds_pkg::t_kmds_out    i_data,
    output kmds_pkg::t_kmds_buf_st o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output kmds_pkg::t_kmds_out    o_out_data
);

    kmds_pkg::t_kmds_out r_head, n_head;
    kmds_pkg::t_kmds_out r_tail, n_tail;
    logic [1:0]          r_cnt,  n_cnt;
    logic                pop;

    assign pop         = (r_cnt != 2'd0) && i_out_ready;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out_data  = r_head;
    assign o_status.room  = r_cnt != 2'd2;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        case (r_cnt)
            2'd0: begin
                if (i_push) begin
                    n_head = i_data;
                    n_cnt  = 2'd1;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    n_head = i_data;
                end else if (i_push) begin
                    n_tail = i_data;
                    n_cnt  = 2'd2;
                end else if (pop) begin
                    n_cnt  = 2'd0;
                end
            end
            2'd2: begin
                // full: no push accepted, advance the tail on a pop
                if (pop) begin
                    n_head = r_tail;
                    n_cnt  = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

// ===== rtl/key_matrix_debounce_scanner_unit.sv =====
// Top level of the key matrix debounce scanner.
// Takes one row reading per transaction and accepts a new one every cycle while
// the output buffer has room. Each reading is registered, then processed in a
// single pass (row mask, scan completion, pairwise debounce and lowest-new-key
// encode) whose result lands in a two-entry output buffer; only a reading of the
// last row yields a result. The output buffer lets readings keep flowing while
// one result waits to be taken. Readings with an out-of-range row index are
// dropped without a result.
module key_matrix_debounce_scanner_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kmds_pkg::t_kmds_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kmds_pkg::t_kmds_out o_out_data
);

    logic                   r_in_valid, n_in_valid;
    kmds_pkg::t_kmds_in     r_in_data;
    kmds_pkg::t_kmds_buf_st buf_st;
    kmds_pkg::t_kmds_res    res;
    logic                   accept;
    logic                   fire;

    assign fire       = r_in_valid && buf_st.room;
    assign o_in_ready = !r_in_valid || buf_st.room;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
    end

    kmds_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (r_in_data),
        .o_res   (res)
    );

    kmds_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res.valid),
        .i_data      (res.data),
        .o_status    (buf_st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A result is only produced when the buffer has room for it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> buf_st.room)
        else $error("result pushed into a full buffer");

    // An accepted reading is held in the input register on the next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("accepted reading lost");

    // No new press reported means key number zero
    a_no_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.key_valid) |-> (o_out_data.key_number == 6'd0))
        else $error("key number set without a new press");

    // A reported press is present in the scan it is reported with
    a_key_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.key_valid) |->
            o_out_data.scan_mask[o_out_data.key_number])
        else $error("reported key missing from scan mask");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the key matrix debounce scanner.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LAST_ROW      = kmds_pkg::NUM_ROWS - 1;
    localparam int KEY_POSITIONS = kmds_pkg::POWER_KEY_BIT + 1;
    localparam int IN_BITS       = $bits(kmds_pkg::t_kmds_in);

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    kmds_pkg::t_kmds_in  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    kmds_pkg::t_kmds_out o_out_data;

    key_matrix_debounce_scanner_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Scanner state as predicted from the accepted readings
    logic [63:0]         acc_mask    = '0;
    logic [63:0]         first_mask  = '0;
    logic [63:0]         held_mask   = '0;
    logic                second_due  = 1'b0;
    kmds_pkg::t_kmds_out exp_scans[$];

    // Keys currently down on the simulated keypad
    logic [63:0] keypad      = '0;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int n_readings    = 0;
    int n_results     = 0;
    int n_presses     = 0;
    int n_errors      = 0;
    int cycle_count   = 0;

    function automatic logic [63:0] row_key_bits(input logic [2:0] row,
                                                 input logic [9:0] levels);
        logic [63:0] m;
        int          pos;
        m = '0;
        for (int c = 0; c < kmds_pkg::NUM_COLS; c++) begin
            pos = int'(row) * kmds_pkg::ROW_STRIDE + c;
            if (pos < kmds_pkg::MASK_BITS && !levels[c]) begin
                m[pos] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [5:0] lowest_key(input logic [63:0] v);
        for (int k = 0; k < kmds_pkg::MASK_BITS; k++) begin
            if (v[k]) begin
                return 6'(k);
            end
        end
        return 6'd0;
    endfunction

    task automatic predict_reading(input kmds_pkg::t_kmds_in rd);
        kmds_pkg::t_kmds_out res;
        logic [63:0]         stable;
        logic [63:0]         fresh;
        if (rd.row_index >= kmds_pkg::NUM_ROWS) begin
            return;
        end
        n_readings++;
        acc_mask |= row_key_bits(rd.row_index, rd.column_levels);
        if (rd.row_index != LAST_ROW) begin
            return;
        end
        if (!rd.power_level) begin
            acc_mask[kmds_pkg::POWER_KEY_BIT] = 1'b1;
        end
        res.scan_mask  = acc_mask;
        res.key_valid  = 1'b0;
        res.key_number = '0;
        acc_mask       = '0;
        if (!second_due) begin
            first_mask = res.scan_mask;
            second_due = 1'b1;
        end else begin
            stable    = first_mask & res.scan_mask;
            fresh     = stable & ~held_mask;
            held_mask = (held_mask & (first_mask | res.scan_mask)) | stable;
            if (fresh != '0) begin
                res.key_valid  = 1'b1;
                res.key_number = lowest_key(fresh);
            end
            second_due = 1'b0;
        end
        exp_scans.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
        n_errors++;
    endtask

    // Called at a rising edge; returns at the edge where the transaction completes.
    task automatic send_reading(input kmds_pkg::t_kmds_in rd);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rd;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_reading(rd);
    endtask

    task automatic send_row(input int row, input logic [9:0] levels, input logic power);
        kmds_pkg::t_kmds_in rd;
        rd.row_index     = 3'(row);
        rd.column_levels = levels;
        rd.power_level   = power;
        send_reading(rd);
    endtask

    // Every key down, then only the power key: power becomes the new press
    task automatic test_full_matrix();
        for (int r = 0; r < kmds_pkg::NUM_ROWS; r++) begin
            send_row(r, 10'h000, 1'b0);
        end
        for (int r = 0; r < kmds_pkg::NUM_ROWS; r++) begin
            send_row(r, 10'h3FF, 1'b0);
        end
    endtask

    // Rows past the matrix are dropped, even with every column low
    task automatic test_ignored_rows();
        send_row(6, 10'h000, 1'b0);
        send_row(7, 10'h000, 1'b1);
    endtask

    // Repeated and skipped rows, a lone last row, and a held key kept from re-reporting
    task automatic test_irregular_order();
        send_row(3, 10'h3F0, 1'b1);
        send_row(3, 10'h0FF, 1'b0);
        send_row(1, 10'h3FE, 1'b0);
        send_row(LAST_ROW, 10'h2FF, 1'b1);
        send_row(LAST_ROW, 10'h000, 1'b0);
        send_row(LAST_ROW, 10'h000, 1'b0);
        send_row(LAST_ROW, 10'h000, 1'b0);
    endtask

    task automatic send_noise();
        logic [IN_BITS-1:0] raw;
        repeat ($urandom_range(1, 4)) begin
            raw = IN_BITS'($urandom);
            send_reading(kmds_pkg::t_kmds_in'(raw));
        end
    endtask

    // One scan of the keypad with an optional bounce; broken scans skip or repeat a row
    task automatic send_keypad_scan(input bit broken);
        logic [63:0] view;
        int          odd_row;
        bit          skip;
        view = keypad;
        if ($urandom_range(0, 99) < 20) begin
            view[$urandom_range(0, KEY_POSITIONS - 1)] ^= 1'b1;
        end
        odd_row = broken ? $urandom_range(0, LAST_ROW - 1) : -1;
        skip    = $urandom_range(0, 1);
        for (int r = 0; r < kmds_pkg::NUM_ROWS; r++) begin
            if ($urandom_range(0, 99) < 4) begin
                send_noise();
            end
            if (r == odd_row && !skip) begin
                send_row(r, 10'($urandom), 1'($urandom));
            end
            if (r != odd_row || !skip) begin
                send_row(r, ~view[r * kmds_pkg::ROW_STRIDE +: 10],
                         (r == LAST_ROW) ? ~view[kmds_pkg::POWER_KEY_BIT] : 1'($urandom));
            end
        end
    endtask

    task automatic test_random_scans(input int in_pct, input int out_pct, input int n_items);
        int start;
        int pick;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start         = n_readings;
        while (n_readings - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                keypad[$urandom_range(0, KEY_POSITIONS - 1)] ^= 1'b1;
            end else if (pick < 33) begin
                keypad = '0;
            end else if (pick < 36) begin
                keypad = {$urandom, $urandom};
                keypad[63:KEY_POSITIONS] = '0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                send_noise();
            end else begin
                send_keypad_scan(pick < 14);
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    kmds_pkg::t_kmds_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_scans.size() == 0) begin
                report_mismatch("result with none pending", o_out_data.scan_mask, '0);
            end else begin
                want = exp_scans.pop_front();
                n_results++;
                if (want.key_valid) begin
                    n_presses++;
                end
                if (o_out_data.scan_mask !== want.scan_mask) begin
                    report_mismatch("scan_mask", o_out_data.scan_mask, want.scan_mask);
                end
                if (o_out_data.key_valid !== want.key_valid) begin
                    report_mismatch("key_valid", 64'(o_out_data.key_valid),
                                    64'(want.key_valid));
                end
                if (o_out_data.key_number !== want.key_number) begin
                    report_mismatch("key_number", 64'(o_out_data.key_number),
                                    64'(want.key_number));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     exp_scans.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_matrix();
        test_ignored_rows();
        test_irregular_order();
        test_random_scans(16, 57, 350);
        test_random_scans(57, 16, 350);
        test_random_scans(0, 0, 350);

        // drop valid and drain
        i_in_valid <= 1'b0;
        while (exp_scans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d scan results (%0d new key presses) from %0d row readings.",
                 n_results, n_presses, n_readings);
        $display("Directed full/empty matrix, dropped and out-of-order rows, then random"
                 , " keypad scans with bounce and noise under three idle mixes.");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kmds_pkg.sv
rtl/kmds_core.sv
rtl/kmds_out_buf.sv
rtl/key_matrix_debounce_scanner_unit.sv
dv/tb_top.sv
